// ===== src/monte_carlo_call_price_accumulator_macros.svh =====
// Assertion macros shared by the accumulator RTL.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef MONTE_CARLO_CALL_PRICE_ACCUMULATOR_MACROS_SVH
`define MONTE_CARLO_CALL_PRICE_ACCUMULATOR_MACROS_SVH

// same-cycle implication, off during reset
`define MCPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define MCPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mcpa_pkg.sv =====
// Package for the Monte Carlo call price accumulator.
// Widths, config register indexes, microcode control types; no dependencies.
`default_nettype none

package mcpa_pkg;

  localparam int SampleW  = 16;
  localparam int SampleFrac = 12;
  localparam int SpotW    = 16;
  localparam int DriftW   = 18;
  localparam int DiffW    = 17;
  localparam int DiscW    = 17;
  localparam int PriceW   = 48;
  localparam int UsedW    = 32;
  localparam int SumW     = 64;
  localparam int CountW   = 32;
  localparam int XW       = 22;
  localparam int T2W      = 24;
  localparam int NW       = 28;
  localparam int T3W      = 27;
  localparam int AccW     = 29;
  localparam int OpW      = 33;
  localparam int ProdW    = 2 * OpW;
  localparam int PloW     = 49;
  localparam int StepW    = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 18;
  localparam int DivSteps = SumW;
  localparam int DivCntW  = $clog2(DivSteps);

  // ceil(2^30 / 3): exact floor(n/3) for n < 2^29
  localparam logic [28:0] Recip3 = 29'd357913942;

  localparam logic [CfgIdxW-1:0] CfgSpot      = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgStrike    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgDrift     = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgDiffusion = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CfgDiscount  = CfgIdxW'(4);

  typedef struct packed {
    logic        [SpotW-1:0]  spot;
    logic        [SpotW-1:0]  strike;
    logic signed [DriftW-1:0] drift;
    logic        [DiffW-1:0]  diffusion;
    logic        [DiscW-1:0]  discount;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SAMPLE_DIFF,
    MUL_X_X,
    MUL_T2_X,
    MUL_N_RECIP,
    MUL_SPOT_APPROX,
    MUL_MEAN_LO,
    MUL_MEAN_HI
  } mul_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_LOAD_X,
    OP_LOAD_T2,
    OP_LOAD_ABS,
    OP_LOAD_T3,
    OP_ACCUM,
    OP_DIV_START,
    OP_SAVE_LO,
    OP_FINISH
  } op_e;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_WAIT_IN,
    BR_NOT_LAST,
    BR_WAIT_DIV,
    BR_WAIT_OUT
  } br_e;

  typedef struct packed {
    mul_e             mul;
    op_e              op;
    br_e              br;
    logic [StepW-1:0] target;
  } uword_t;

  typedef struct packed {
    mul_e mul;
    op_e  op;
    logic fire;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic last;
    logic div_busy;
    logic out_hold;
  } status_t;

endpackage

`default_nettype wire

// ===== src/mcpa_channels.sv =====
// Channel interfaces: sample input, result output, config write.
// Depends on mcpa_pkg for field widths.
`default_nettype none

interface mcpa_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [mcpa_pkg::SampleW-1:0] normal_sample;
  logic                                last_sample;
  modport source(output valid, normal_sample, last_sample, input ready);
  modport sink(input valid, normal_sample, last_sample, output ready);
endinterface

interface mcpa_result_if;
  logic                         valid;
  logic                         ready;
  logic [mcpa_pkg::PriceW-1:0]  option_price;
  logic [mcpa_pkg::UsedW-1:0]   samples_used;
  logic                         saturated;
  modport source(output valid, option_price, samples_used, saturated, input ready);
  modport sink(input valid, option_price, samples_used, saturated, output ready);
endinterface

interface mcpa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mcpa_pkg::CfgIdxW-1:0]  index;
  logic [mcpa_pkg::CfgDataW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/mcpa_divider.sv =====
// Restoring divider, one quotient bit per cycle: payoff sum / sample count.
// Depends on mcpa_pkg and the assertion macro header.
`default_nettype none
`include "monte_carlo_call_price_accumulator_macros.svh"

module mcpa_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mcpa_pkg::SumW-1:0]     dividend_i,
  input  logic [mcpa_pkg::CountW-1:0]   divisor_i,
  output logic                          busy_o,
  output logic [mcpa_pkg::SumW-1:0]     quotient_o
);

  localparam logic [mcpa_pkg::DivCntW-1:0] LastStep =
    mcpa_pkg::DivCntW'(mcpa_pkg::DivSteps - 1);

  logic                          busy_q;
  logic [mcpa_pkg::DivCntW-1:0]  step_q;
  logic [mcpa_pkg::SumW-1:0]     quot_q;
  logic [mcpa_pkg::CountW-1:0]   rem_q;
  logic [mcpa_pkg::CountW-1:0]   dvs_q;
  logic [mcpa_pkg::CountW:0]     shifted;
  logic [mcpa_pkg::CountW:0]     trial;
  logic                          qbit;

  always_comb begin
    shifted = {rem_q, quot_q[mcpa_pkg::SumW-1]};
    trial   = shifted - {1'b0, dvs_q};
    qbit    = !trial[mcpa_pkg::CountW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      quot_q <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= qbit ? trial[mcpa_pkg::CountW-1:0] : shifted[mcpa_pkg::CountW-1:0];
      quot_q <= {quot_q[mcpa_pkg::SumW-2:0], qbit};
      step_q <= step_q + 1'b1;
      if (step_q == LastStep) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quot_q;

  `MCPA_ASSERT_NOW(a_no_restart, start_i, !busy_q, "divider restarted while busy")
  `MCPA_ASSERT_NEXT(a_busy_after_start, start_i, busy_q, "divider did not go busy")
  `MCPA_ASSERT_NEXT(a_done_in_time, busy_q && step_q == LastStep, !busy_q,
                    "divider overran its step count")

endmodule

`default_nettype wire

// ===== src/mcpa_sequencer.sv =====
// Microcode sequencer: step counter, control-word ROM and branch logic.
// Depends on mcpa_pkg.
`default_nettype none

module mcpa_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mcpa_pkg::status_t status_i,
  output mcpa_pkg::ctrl_t   ctrl_o,
  output logic              in_ready_o
);

  localparam logic [mcpa_pkg::StepW-1:0] StepIdle     = 4'd0;
  localparam logic [mcpa_pkg::StepW-1:0] StepMulA     = 4'd1;
  localparam logic [mcpa_pkg::StepW-1:0] StepLoadX    = 4'd2;
  localparam logic [mcpa_pkg::StepW-1:0] StepMulSq    = 4'd3;
  localparam logic [mcpa_pkg::StepW-1:0] StepLoadT2   = 4'd4;
  localparam logic [mcpa_pkg::StepW-1:0] StepMulCube  = 4'd5;
  localparam logic [mcpa_pkg::StepW-1:0] StepLoadAbs  = 4'd6;
  localparam logic [mcpa_pkg::StepW-1:0] StepMulRecip = 4'd7;
  localparam logic [mcpa_pkg::StepW-1:0] StepLoadT3   = 4'd8;
  localparam logic [mcpa_pkg::StepW-1:0] StepMulSpot  = 4'd9;
  localparam logic [mcpa_pkg::StepW-1:0] StepAccum    = 4'd10;
  localparam logic [mcpa_pkg::StepW-1:0] StepDivStart = 4'd11;
  localparam logic [mcpa_pkg::StepW-1:0] StepDivWait  = 4'd12;
  localparam logic [mcpa_pkg::StepW-1:0] StepMulLo    = 4'd13;
  localparam logic [mcpa_pkg::StepW-1:0] StepMulHi    = 4'd14;
  localparam logic [mcpa_pkg::StepW-1:0] StepFinish   = 4'd15;

  function automatic mcpa_pkg::uword_t ucode_word(input logic [mcpa_pkg::StepW-1:0] s);
    mcpa_pkg::uword_t w;
    w = '{mul: mcpa_pkg::MUL_NONE, op: mcpa_pkg::OP_NONE, br: mcpa_pkg::BR_NEXT,
          target: StepIdle};
    unique case (s)
      StepIdle: begin
        w.op = mcpa_pkg::OP_CAPTURE;
        w.br = mcpa_pkg::BR_WAIT_IN;
      end
      StepMulA:     w.mul = mcpa_pkg::MUL_SAMPLE_DIFF;
      StepLoadX:    w.op  = mcpa_pkg::OP_LOAD_X;
      StepMulSq:    w.mul = mcpa_pkg::MUL_X_X;
      StepLoadT2:   w.op  = mcpa_pkg::OP_LOAD_T2;
      StepMulCube:  w.mul = mcpa_pkg::MUL_T2_X;
      StepLoadAbs:  w.op  = mcpa_pkg::OP_LOAD_ABS;
      StepMulRecip: w.mul = mcpa_pkg::MUL_N_RECIP;
      StepLoadT3:   w.op  = mcpa_pkg::OP_LOAD_T3;
      StepMulSpot:  w.mul = mcpa_pkg::MUL_SPOT_APPROX;
      StepAccum: begin
        w.op = mcpa_pkg::OP_ACCUM;
        w.br = mcpa_pkg::BR_NOT_LAST;
      end
      StepDivStart: w.op = mcpa_pkg::OP_DIV_START;
      StepDivWait:  w.br = mcpa_pkg::BR_WAIT_DIV;
      StepMulLo:    w.mul = mcpa_pkg::MUL_MEAN_LO;
      StepMulHi: begin
        w.mul = mcpa_pkg::MUL_MEAN_HI;
        w.op  = mcpa_pkg::OP_SAVE_LO;
      end
      StepFinish: begin
        w.op = mcpa_pkg::OP_FINISH;
        w.br = mcpa_pkg::BR_WAIT_OUT;
      end
      default: ;
    endcase
    return w;
  endfunction

  logic [mcpa_pkg::StepW-1:0] step_q, step_d;
  mcpa_pkg::uword_t           word;
  logic                       fire;

  always_comb begin
    word   = ucode_word(step_q);
    fire   = 1'b1;
    step_d = step_q + 1'b1;
    unique case (word.br)
      mcpa_pkg::BR_NEXT: ;
      mcpa_pkg::BR_WAIT_IN: begin
        fire   = status_i.start;
        step_d = status_i.start ? step_q + 1'b1 : step_q;
      end
      mcpa_pkg::BR_NOT_LAST: begin
        step_d = status_i.last ? step_q + 1'b1 : word.target;
      end
      mcpa_pkg::BR_WAIT_DIV: begin
        fire   = !status_i.div_busy;
        step_d = status_i.div_busy ? step_q : step_q + 1'b1;
      end
      mcpa_pkg::BR_WAIT_OUT: begin
        fire   = !status_i.out_hold;
        step_d = status_i.out_hold ? step_q : word.target;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o     = '{mul: word.mul, op: word.op, fire: fire};
  assign in_ready_o = (step_q == StepIdle);

endmodule

`default_nettype wire

// ===== src/mcpa_datapath.sv =====
// Datapath: shared 33x33 multiplier, Taylor terms, payoff accumulators, result register.
// Depends on mcpa_pkg, mcpa_divider and the assertion macro header.
`default_nettype none
`include "monte_carlo_call_price_accumulator_macros.svh"

module mcpa_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mcpa_pkg::ctrl_t                     ctrl_i,
  input  mcpa_pkg::cfg_t                      cfg_i,
  input  logic                                start_i,
  input  logic signed [mcpa_pkg::SampleW-1:0] normal_sample_i,
  input  logic                                last_sample_i,
  output mcpa_pkg::status_t                   status_o,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output logic [mcpa_pkg::PriceW-1:0]         option_price_o,
  output logic [mcpa_pkg::UsedW-1:0]          samples_used_o,
  output logic                                saturated_o
);

  localparam int FinW = mcpa_pkg::PloW + 32;

  logic signed [mcpa_pkg::SampleW-1:0] samp_q;
  logic                                last_q;
  logic signed [mcpa_pkg::XW-1:0]      x_q, x_d;
  logic        [mcpa_pkg::T2W-1:0]     t2_q;
  logic        [mcpa_pkg::NW-1:0]      n_q;
  logic                                neg_q;
  logic signed [mcpa_pkg::AccW-1:0]    acc_q, acc_t3;
  logic signed [mcpa_pkg::ProdW-1:0]   prod_q;
  logic        [mcpa_pkg::PloW-1:0]    plo_q;
  logic        [mcpa_pkg::SumW-1:0]    sum_q;
  logic        [mcpa_pkg::CountW-1:0]  cnt_q;
  logic                                ovf_q;
  logic                                res_valid_q;
  logic        [mcpa_pkg::PriceW-1:0]  res_price_q;
  logic        [mcpa_pkg::UsedW-1:0]   res_used_q;
  logic                                res_sat_q;

  logic signed [mcpa_pkg::OpW-1:0]     mul_a, mul_b;
  logic signed [33:0]                  ax_prod, ax_bias, ax_shift;
  logic signed [44:0]                  cube;
  logic        [44:0]                  cube_mag;
  logic        [mcpa_pkg::T3W-1:0]     q3;
  logic signed [45:0]                  price;
  logic signed [46:0]                  strike_q16, diff;
  logic        [mcpa_pkg::PriceW-1:0]  payoff;
  logic        [mcpa_pkg::SumW:0]      sum_ext;
  logic        [FinW-1:0]              fin;
  logic                                fin_sat;
  logic        [47:0]                  cnt_w;
  logic        [mcpa_pkg::SumW-1:0]    mean;
  logic                                div_busy, div_start, finish_fire;

  assign div_start   = ctrl_i.fire && (ctrl_i.op == mcpa_pkg::OP_DIV_START);
  assign finish_fire = ctrl_i.fire && (ctrl_i.op == mcpa_pkg::OP_FINISH);

  mcpa_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .busy_o     (div_busy),
    .quotient_o (mean)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl_i.mul)
      mcpa_pkg::MUL_SAMPLE_DIFF: begin
        mul_a = mcpa_pkg::OpW'(samp_q);
        mul_b = mcpa_pkg::OpW'(cfg_i.diffusion);
      end
      mcpa_pkg::MUL_X_X: begin
        mul_a = mcpa_pkg::OpW'(x_q);
        mul_b = mcpa_pkg::OpW'(x_q);
      end
      mcpa_pkg::MUL_T2_X: begin
        mul_a = mcpa_pkg::OpW'(t2_q);
        mul_b = mcpa_pkg::OpW'(x_q);
      end
      mcpa_pkg::MUL_N_RECIP: begin
        mul_a = mcpa_pkg::OpW'(n_q);
        mul_b = mcpa_pkg::OpW'(mcpa_pkg::Recip3);
      end
      mcpa_pkg::MUL_SPOT_APPROX: begin
        mul_a = mcpa_pkg::OpW'(cfg_i.spot);
        mul_b = mcpa_pkg::OpW'(acc_q);
      end
      mcpa_pkg::MUL_MEAN_LO: begin
        mul_a = mcpa_pkg::OpW'(mean[31:0]);
        mul_b = mcpa_pkg::OpW'(cfg_i.discount);
      end
      mcpa_pkg::MUL_MEAN_HI: begin
        mul_a = mcpa_pkg::OpW'(mean[63:32]);
        mul_b = mcpa_pkg::OpW'(cfg_i.discount);
      end
      default: ;
    endcase
  end

  always_comb begin
    // sample*diffusion / 4096, truncated toward zero, plus drift
    ax_prod  = prod_q[33:0];
    ax_bias  = ax_prod + (ax_prod[33] ? 34'sd4095 : 34'sd0);
    ax_shift = ax_bias >>> mcpa_pkg::SampleFrac;
    x_d      = mcpa_pkg::XW'(ax_shift) + mcpa_pkg::XW'(cfg_i.drift);

    // |t2*x| / 65536, later / 3 by reciprocal
    cube     = prod_q[44:0];
    cube_mag = cube[44] ? 45'(-cube) : 45'(cube);
    q3       = prod_q[56:30];
    acc_t3   = acc_q + mcpa_pkg::AccW'(t2_q)
             + (neg_q ? -mcpa_pkg::AccW'(q3) : mcpa_pkg::AccW'(q3));

    price      = prod_q[45:0];
    strike_q16 = {15'd0, cfg_i.strike, 16'd0};
    diff       = 47'(price) - strike_q16;
    payoff     = (!diff[46] && diff != '0) ? mcpa_pkg::PriceW'(diff[45:0]) : '0;
    sum_ext    = {1'b0, sum_q} + (mcpa_pkg::SumW + 1)'(payoff);

    fin     = {prod_q[mcpa_pkg::PloW-1:0], 32'd0} + FinW'(plo_q);
    fin_sat = (fin[FinW-1:64] != '0);
    cnt_w   = 48'(cnt_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul != mcpa_pkg::MUL_NONE) begin
      prod_q <= mcpa_pkg::ProdW'(mul_a) * mcpa_pkg::ProdW'(mul_b);
    end
    if (ctrl_i.fire) begin
      unique case (ctrl_i.op)
        mcpa_pkg::OP_CAPTURE: begin
          samp_q <= normal_sample_i;
          last_q <= last_sample_i;
        end
        mcpa_pkg::OP_LOAD_X: x_q <= x_d;
        mcpa_pkg::OP_LOAD_T2: begin
          t2_q  <= prod_q[mcpa_pkg::T2W+16:17];
          acc_q <= mcpa_pkg::AccW'(65536) + mcpa_pkg::AccW'(x_q);
        end
        mcpa_pkg::OP_LOAD_ABS: begin
          n_q   <= cube_mag[43:16];
          neg_q <= cube[44];
        end
        mcpa_pkg::OP_LOAD_T3: acc_q <= acc_t3;
        mcpa_pkg::OP_SAVE_LO: plo_q <= prod_q[mcpa_pkg::PloW-1:0];
        mcpa_pkg::OP_FINISH: begin
          res_price_q <= fin_sat ? '1 : fin[63:16];
          res_used_q  <= (cnt_w[47:32] != '0) ? '1 : cnt_w[31:0];
          res_sat_q   <= ovf_q || fin_sat;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (finish_fire) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
      if (finish_fire) begin
        sum_q <= '0;
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else if (ctrl_i.fire && ctrl_i.op == mcpa_pkg::OP_ACCUM) begin
        if (sum_ext[mcpa_pkg::SumW]) begin
          sum_q <= '1;
        end else begin
          sum_q <= sum_ext[mcpa_pkg::SumW-1:0];
        end
        if (cnt_q != '1) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (sum_ext[mcpa_pkg::SumW] || cnt_q == '1) begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  assign status_o = '{start: start_i, last: last_q, div_busy: div_busy,
                      out_hold: res_valid_q && !res_ready_i};

  assign res_valid_o    = res_valid_q;
  assign option_price_o = res_price_q;
  assign samples_used_o = res_used_q;
  assign saturated_o    = res_sat_q;

  `MCPA_ASSERT_NOW(a_res_from_finish, $rose(res_valid_q), $past(finish_fire),
                   "result raised outside finish step")
  `MCPA_ASSERT_NEXT(a_clear_after_finish, finish_fire,
                    cnt_q == '0 && sum_q == '0 && !ovf_q, "run state not cleared")
  `MCPA_ASSERT_NOW(a_finish_not_blocked, finish_fire, !(res_valid_q && !res_ready_i),
                   "result overwritten while held")

endmodule

`default_nettype wire

// ===== src/monte_carlo_call_price_accumulator.sv =====
// Non-last sample: accepted at step 0, ready again once the program returns to step 0 after its
// accumulate step (shared multiplier, 16-step program). Last sample: the result is valid after
// the one-bit-per-cycle divider for sum/count, then two 32x17 partial products.
// A new sample is taken only at step 0, when the previous one is through; one result per run.
// rst_ni is asynchronous, active low: config to defaults, accumulators and control cleared.
// Top level: config registers, channel handshakes, sequencer and datapath.
`default_nettype none

module monte_carlo_call_price_accumulator (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mcpa_cfg_if.sink              cfg_i,
  mcpa_sample_if.sink           sample_i,
  mcpa_result_if.source         result_o
);

  mcpa_pkg::cfg_t    cfg_q;
  mcpa_pkg::ctrl_t   ctrl;
  mcpa_pkg::status_t status;
  logic              in_ready;
  logic              start;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spot      <= 16'd100;
      cfg_q.strike    <= 16'd110;
      cfg_q.drift     <= '0;
      cfg_q.diffusion <= 17'd13107;
      cfg_q.discount  <= 17'd61693;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mcpa_pkg::CfgSpot:      cfg_q.spot      <= cfg_i.data[mcpa_pkg::SpotW-1:0];
        mcpa_pkg::CfgStrike:    cfg_q.strike    <= cfg_i.data[mcpa_pkg::SpotW-1:0];
        mcpa_pkg::CfgDrift:     cfg_q.drift     <= cfg_i.data[mcpa_pkg::DriftW-1:0];
        mcpa_pkg::CfgDiffusion: cfg_q.diffusion <= cfg_i.data[mcpa_pkg::DiffW-1:0];
        mcpa_pkg::CfgDiscount:  cfg_q.discount  <= cfg_i.data[mcpa_pkg::DiscW-1:0];
        default: ;
      endcase
    end
  end

  assign sample_i.ready = in_ready;
  assign start          = sample_i.valid && in_ready;

  mcpa_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .in_ready_o (in_ready)
  );

  mcpa_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .cfg_i           (cfg_q),
    .start_i         (start),
    .normal_sample_i (sample_i.normal_sample),
    .last_sample_i   (sample_i.last_sample),
    .status_o        (status),
    .res_valid_o     (result_o.valid),
    .res_ready_i     (result_o.ready),
    .option_price_o  (result_o.option_price),
    .samples_used_o  (result_o.samples_used),
    .saturated_o     (result_o.saturated)
  );

endmodule

`default_nettype wire
